@@ hdl/mlbs_pkg.sv @@
// Shared types and codes for the multi-LED blink sequencer.
// Used by mlbs_step_unit and multi_led_blink_sequencer_unit; depends on nothing.
`default_nettype none

package mlbs_pkg;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned PIN_W  = 4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_ON    = 3'd2,
        PH_OFF   = 3'd3,
        PH_COUNT = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_STARTED = 2'd1,
        EV_IDLE    = 2'd2
    } t_event;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_BAD_INDEX = 1'b1;

    // Working copy of one LED while its tick is being run.
    typedef struct packed {
        t_phase              ph;
        logic [TICK_W-1:0]   cur;
        logic [TICK_W-1:0]   cnt;
        logic                lv;
        logic                first;
    } t_work;

endpackage

`default_nettype wire

@@ hdl/mlbs_step_unit.sv @@
// One phase transition of a single LED: the shared unit the sequencer reuses.
// Depends on mlbs_pkg.
`default_nettype none

module mlbs_step_unit (
    input  wire mlbs_pkg::t_work                  i_work,
    input  wire logic [mlbs_pkg::TICK_W-1:0]      i_on_len,
    input  wire logic [mlbs_pkg::TICK_W-1:0]      i_off_len,
    output mlbs_pkg::t_work                       o_work,
    output logic                                  o_more
);

    always_comb begin
        o_work = i_work;
        o_more = 1'b0;
        unique case (i_work.ph)
            mlbs_pkg::PH_START: begin
                o_work.cur   = i_on_len;
                o_work.first = 1'b1;
                o_work.ph    = mlbs_pkg::PH_ON;
                o_more       = 1'b1;
            end
            mlbs_pkg::PH_ON: begin
                if (i_work.cur == '0) begin
                    o_work.cur   = i_off_len;
                    o_work.first = 1'b1;
                    o_work.ph    = mlbs_pkg::PH_OFF;
                    o_more       = 1'b1;
                end else begin
                    if (i_work.first) begin
                        o_work.first = 1'b0;
                        o_work.lv    = 1'b1;
                    end
                    o_work.cur = i_work.cur - 1'b1;
                end
            end
            mlbs_pkg::PH_OFF: begin
                if (i_work.cur == '0) begin
                    o_work.first = 1'b1;
                    o_work.ph    = mlbs_pkg::PH_COUNT;
                    o_more       = 1'b1;
                end else begin
                    if (i_work.first) begin
                        o_work.first = 1'b0;
                        o_work.lv    = 1'b0;
                    end
                    o_work.cur = i_work.cur - 1'b1;
                end
            end
            mlbs_pkg::PH_COUNT: begin
                o_work.first = 1'b1;
                o_more       = 1'b1;
                if (i_work.cnt == mlbs_pkg::TICK_W'(1)) begin
                    o_work.ph = mlbs_pkg::PH_IDLE;
                end else begin
                    // count above one decrements, zero repeats forever
                    if (i_work.cnt != '0) begin
                        o_work.cnt = i_work.cnt - 1'b1;
                    end
                    o_work.cur = i_on_len;
                    o_work.ph  = mlbs_pkg::PH_ON;
                end
            end
            mlbs_pkg::PH_IDLE: begin
                o_work.lv = 1'b0;
            end
            default: begin
                // unused phase codes end the run with no change
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/multi_led_blink_sequencer_unit.sv @@
// Top level of the multi-LED blink sequencer: request sequencer and LED state.
// Depends on mlbs_pkg and mlbs_step_unit.
`default_nettype none

// Command-style block: an item transfers at a clock edge with start high and busy
// low, and exactly one result follows, shown for one cycle with o_valid high. The
// receiver cannot stall, so the result must be sampled in that cycle. Start, stop
// and unknown requests, and ticks while the timer is stopped, go straight to the
// final state, and the result is strobed in the cycle after it. A tick with the
// timer running walks the LEDs one at a time through the shared step unit, one
// phase transition per cycle: each LED is visited, and each LED that is not idle
// then runs its transitions (at most LOOP_LIMIT + 1 per LED, the last one then
// flagging the overrun); an end state and the final state follow. The active-low
// mask is written over its own channel, which is always ready; write it only
// while the block is idle. pin_levels is the LED state after the item, each bit
// inverted where the mask bit is set; LEDs at index four and up have no pin or
// error bit.
module multi_led_blink_sequencer_unit #(
    parameter int unsigned NUM_LEDS   = 4,
    parameter int unsigned LOOP_LIMIT = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [2:0]  i_led_index,
    input  wire logic [15:0] i_on_ticks,
    input  wire logic [15:0] i_off_ticks,
    input  wire logic [15:0] i_repeat_count,
    // result strobe
    output logic             o_valid,
    output logic [3:0]       o_pin_levels,
    output logic             o_status,
    output logic [1:0]       o_event_res,
    output logic [3:0]       o_error_mask,
    // active-low mask register
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data
);

    localparam int unsigned LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int unsigned N_W   = $clog2(LOOP_LIMIT + 1);
    localparam int unsigned TW    = mlbs_pkg::TICK_W;
    localparam int unsigned PW    = mlbs_pkg::PIN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VISIT,
        S_STEP,
        S_END,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [LED_W-1:0]    r_led;
    logic [N_W-1:0]      r_n;
    logic                r_any;
    logic                r_timer;
    logic [PW-1:0]       r_mask;
    logic [PW-1:0]       r_err;
    logic                r_status;
    mlbs_pkg::t_event    r_event;
    mlbs_pkg::t_work     r_work;

    // per-LED state
    mlbs_pkg::t_phase    r_phase  [NUM_LEDS];
    logic [TW-1:0]       r_remain [NUM_LEDS];
    logic [TW-1:0]       r_cycles [NUM_LEDS];
    logic [TW-1:0]       r_on_len [NUM_LEDS];
    logic [TW-1:0]       r_off_len[NUM_LEDS];
    logic [NUM_LEDS-1:0] r_lit;

    // registered result
    logic                r_valid;
    logic [PW-1:0]       r_pins;
    logic                r_o_status;
    mlbs_pkg::t_event    r_o_event;
    logic [PW-1:0]       r_o_err;

    mlbs_pkg::t_work     w_next;
    logic                w_more;
    logic [PW-1:0]       w_led_sel;
    logic [PW-1:0]       w_pins;
    logic [PW-1:0]       n_err;
    logic                w_accept;
    logic                w_last;
    logic                w_idx_ok;
    logic [LED_W-1:0]    w_idx;
    logic                w_limit;
    logic                w_tick_run;
    logic                w_start_ok;

    mlbs_step_unit u_step (
        .i_work    (r_work),
        .i_on_len  (r_on_len[r_led]),
        .i_off_len (r_off_len[r_led]),
        .o_work    (w_next),
        .o_more    (w_more)
    );

    // decode the LED under work and the pin levels; LEDs beyond four have no bit
    for (genvar k = 0; k < PW; k++) begin : g_pins
        if (k < NUM_LEDS) begin : g_used
            assign w_led_sel[k] = (r_led == LED_W'(k));
            assign w_pins[k]    = r_lit[k] ^ r_mask[k];
        end else begin : g_unused
            assign w_led_sel[k] = 1'b0;
            assign w_pins[k]    = 1'b0;
        end
    end

    assign w_accept    = start && !busy;
    assign w_last      = (r_led == LED_W'(NUM_LEDS - 1));
    assign w_idx_ok    = ({1'b0, i_led_index} < 4'(NUM_LEDS));
    assign w_idx       = i_led_index[LED_W-1:0];
    assign w_limit     = (r_n == N_W'(LOOP_LIMIT));
    assign w_tick_run  = (i_req_type == mlbs_pkg::REQ_TICK) && r_timer;
    assign w_start_ok  = (i_req_type == mlbs_pkg::REQ_START) && w_idx_ok;
    assign n_err       = r_err | w_led_sel;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_valid      = r_valid;
    assign o_pin_levels = r_pins;
    assign o_status     = r_o_status;
    assign o_event_res  = r_o_event;
    assign o_error_mask = r_o_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_timer <= 1'b0;
            r_mask  <= '0;
            r_lit   <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_phase[i] <= mlbs_pkg::PH_IDLE;
            end
        end else begin
            // strobe the result in the cycle after the final state
            r_valid <= (r_state == S_FIN);
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_err <= '0;
                        r_led <= '0;
                        r_any <= 1'b0;
                        // only a tick with the timer running walks the LEDs
                        if (w_tick_run) begin
                            r_state <= S_VISIT;
                        end else begin
                            r_state <= S_FIN;
                        end
                        if (i_req_type == mlbs_pkg::REQ_START && !w_idx_ok) begin
                            r_status <= mlbs_pkg::ST_BAD_INDEX;
                        end else begin
                            r_status <= mlbs_pkg::ST_OK;
                        end
                        if (w_start_ok) begin
                            r_event <= mlbs_pkg::EV_STARTED;
                        end else begin
                            r_event <= mlbs_pkg::EV_NONE;
                        end
                        case (i_req_type)
                            mlbs_pkg::REQ_START: begin
                                if (w_idx_ok) begin
                                    r_on_len[w_idx]  <= i_on_ticks;
                                    r_off_len[w_idx] <= i_off_ticks;
                                    r_cycles[w_idx]  <= i_repeat_count;
                                    if (i_on_ticks != '0 && i_off_ticks == '0
                                            && i_repeat_count == '0) begin
                                        // steady on
                                        r_lit[w_idx]   <= 1'b1;
                                        r_phase[w_idx] <= mlbs_pkg::PH_IDLE;
                                    end else if (i_on_ticks == '0
                                            && i_repeat_count == '0) begin
                                        // steady off
                                        r_lit[w_idx]   <= 1'b0;
                                        r_phase[w_idx] <= mlbs_pkg::PH_IDLE;
                                    end else begin
                                        r_lit[w_idx]   <= 1'b0;
                                        r_phase[w_idx] <= mlbs_pkg::PH_START;
                                        r_timer        <= 1'b1;
                                    end
                                end
                            end
                            mlbs_pkg::REQ_STOP: begin
                                r_timer <= 1'b0;
                                r_lit   <= '0;
                                for (int i = 0; i < NUM_LEDS; i++) begin
                                    r_phase[i] <= mlbs_pkg::PH_IDLE;
                                end
                            end
                            default: begin
                                // ticks are handled by the state move; unknown
                                // requests change nothing
                            end
                        endcase
                    end
                end
                S_VISIT: begin
                    if (r_phase[r_led] != mlbs_pkg::PH_IDLE) begin
                        // load the working copy and run transitions
                        r_work.ph    <= r_phase[r_led];
                        r_work.cur   <= r_remain[r_led];
                        r_work.cnt   <= r_cycles[r_led];
                        r_work.lv    <= r_lit[r_led];
                        r_work.first <= 1'b0;
                        r_n          <= '0;
                        r_any        <= 1'b1;
                        r_state      <= S_STEP;
                    end else if (w_last) begin
                        r_state <= S_END;
                    end else begin
                        r_led <= r_led + 1'b1;
                    end
                end
                S_STEP: begin
                    if (w_limit || !w_more) begin
                        if (w_limit) begin
                            // overrun: drop the working copy, flag the LED
                            r_err <= n_err;
                        end else begin
                            r_phase[r_led]  <= w_next.ph;
                            r_remain[r_led] <= w_next.cur;
                            r_cycles[r_led] <= w_next.cnt;
                            r_lit[r_led]    <= w_next.lv;
                        end
                        if (w_last) begin
                            r_state <= S_END;
                        end else begin
                            r_led   <= r_led + 1'b1;
                            r_state <= S_VISIT;
                        end
                    end else begin
                        r_work <= w_next;
                        r_n    <= r_n + 1'b1;
                    end
                end
                S_END: begin
                    if (!r_any) begin
                        r_timer <= 1'b0;
                        r_event <= mlbs_pkg::EV_IDLE;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload: no reset needed, qualified by r_valid
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            r_pins     <= w_pins;
            r_o_status <= r_status;
            r_o_event  <= r_event;
            r_o_err    <= r_err;
        end
    end

    // a result is a single-cycle strobe
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // an accepted request always keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a request transfer");

    // the transition counter never passes the limit
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_n <= N_W'(LOOP_LIMIT)))
        else $error("transition counter beyond limit");

    // overrun bits only come with a tick that found work to do
    a_err_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_mask != '0) |->
            (o_event_res == mlbs_pkg::EV_NONE && o_status == mlbs_pkg::ST_OK))
        else $error("error mask reported outside an active tick");

endmodule

`default_nettype wire

@@ sim/tb_multi_led_blink_sequencer_unit.sv @@
// Self-checking testbench for multi_led_blink_sequencer_unit: blink requests,
// ticks and stops against a cycle-free LED pattern predictor.
// Depends on mlbs_pkg and the sequencer RTL.
`timescale 1ns / 100ps

module tb_multi_led_blink_sequencer_unit;

    localparam int unsigned NUM_LEDS    = 4;
    localparam int unsigned LOOP_LIMIT  = 10;
    // Settle for longer than the longest busy stretch of one tick.
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned DRAIN_LIMIT   = 400;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    // Request code outside the defined set; the block must ignore it.
    localparam logic [1:0]  REQ_UNKNOWN   = 2'd3;

    typedef struct packed {
        logic [1:0]  req;
        logic [2:0]  idx;
        logic [15:0] on_len;
        logic [15:0] off_len;
        logic [15:0] reps;
        logic        drain;   // hold this item until every pending result is back
    } t_blink_item;

    typedef struct packed {
        logic [3:0]       pins;
        logic             status;
        mlbs_pkg::t_event ev;
        logic [3:0]       err;
    } t_pin_result;

    // DUT connections
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type     = '0;
    logic [2:0]  i_led_index    = '0;
    logic [15:0] i_on_ticks     = '0;
    logic [15:0] i_off_ticks    = '0;
    logic [15:0] i_repeat_count = '0;
    logic        o_valid;
    logic [3:0]  o_pin_levels;
    logic        o_status;
    logic [1:0]  o_event_res;
    logic [3:0]  o_error_mask;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data     = '0;

    // Predictor state: one copy of every LED plus the shared timer and mask.
    mlbs_pkg::t_phase led_phase   [NUM_LEDS];
    logic [15:0]      led_remain  [NUM_LEDS];
    logic [15:0]      led_cycles  [NUM_LEDS];
    logic [15:0]      led_on_len  [NUM_LEDS];
    logic [15:0]      led_off_len [NUM_LEDS];
    logic             led_lit     [NUM_LEDS];
    logic             timer_on;
    logic [3:0]       cfg_mask;

    // Stimulus and scoreboard bookkeeping
    t_blink_item pend_q[$];
    t_pin_result pin_result_q[$];
    bit          item_taken = 1'b0;   // set at the edge a transfer happens
    bit          no_idle    = 1'b0;
    int unsigned gap_left   = 0;
    int unsigned fail_cnt   = 0;
    int unsigned cycle_cnt  = 0;

    multi_led_blink_sequencer_unit #(
        .NUM_LEDS   (NUM_LEDS),
        .LOOP_LIMIT (LOOP_LIMIT)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_led_index    (i_led_index),
        .i_on_ticks     (i_on_ticks),
        .i_off_ticks    (i_off_ticks),
        .i_repeat_count (i_repeat_count),
        .o_valid        (o_valid),
        .o_pin_levels   (o_pin_levels),
        .o_status       (o_status),
        .o_event_res    (o_event_res),
        .o_error_mask   (o_error_mask),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_leds();
        for (int unsigned n = 0; n < NUM_LEDS; n++) begin
            led_phase[n]   = mlbs_pkg::PH_IDLE;
            led_remain[n]  = '0;
            led_cycles[n]  = '0;
            led_on_len[n]  = '0;
            led_off_len[n] = '0;
            led_lit[n]     = 1'b0;
        end
        timer_on = 1'b0;
    endfunction

    // Run one LED through the phase transitions of one tick. Work on local
    // copies and drop them on overrun so the LED keeps its old state.
    function automatic bit step_led(int unsigned n);
        logic [15:0]      cnt;
        logic [15:0]      cur;
        mlbs_pkg::t_phase ph;
        logic             lv;
        logic             first;
        logic             more;
        int unsigned      trans;
        cnt   = led_cycles[n];
        cur   = led_remain[n];
        ph    = led_phase[n];
        lv    = led_lit[n];
        first = 1'b0;
        more  = 1'b1;
        trans = 0;
        while (more) begin
            trans++;
            if (trans > LOOP_LIMIT)
                return 1'b1;
            more = 1'b0;
            case (ph)
                mlbs_pkg::PH_START: begin
                    cur   = led_on_len[n];
                    more  = 1'b1;
                    first = 1'b1;
                    ph    = mlbs_pkg::PH_ON;
                end
                mlbs_pkg::PH_ON: begin
                    if (cur == 0) begin
                        cur   = led_off_len[n];
                        more  = 1'b1;
                        first = 1'b1;
                        ph    = mlbs_pkg::PH_OFF;
                    end else begin
                        if (first) begin
                            first = 1'b0;
                            lv    = 1'b1;
                        end
                        cur = cur - 16'd1;
                    end
                end
                mlbs_pkg::PH_OFF: begin
                    if (cur == 0) begin
                        more  = 1'b1;
                        first = 1'b1;
                        ph    = mlbs_pkg::PH_COUNT;
                    end else begin
                        if (first) begin
                            first = 1'b0;
                            lv    = 1'b0;
                        end
                        cur = cur - 16'd1;
                    end
                end
                mlbs_pkg::PH_COUNT: begin
                    more  = 1'b1;
                    first = 1'b1;
                    if (cnt > 1) begin
                        cnt = cnt - 16'd1;
                        cur = led_on_len[n];
                        ph  = mlbs_pkg::PH_ON;
                    end else if (cnt == 1) begin
                        ph = mlbs_pkg::PH_IDLE;
                    end else begin
                        cur = led_on_len[n];
                        ph  = mlbs_pkg::PH_ON;
                    end
                end
                mlbs_pkg::PH_IDLE: begin
                    lv = 1'b0;
                end
                default: ;
            endcase
        end
        led_cycles[n] = cnt;
        led_remain[n] = cur;
        led_phase[n]  = ph;
        led_lit[n]    = lv;
        return 1'b0;
    endfunction

    // Apply one request to the predictor state and return the result it owes.
    function automatic t_pin_result blink_predict(t_blink_item it);
        t_pin_result r;
        int unsigned n;
        bit          none_active;
        r        = '0;
        r.ev     = mlbs_pkg::EV_NONE;
        r.status = mlbs_pkg::ST_OK;
        case (it.req)
            mlbs_pkg::REQ_TICK: begin
                // A tick with the timer stopped changes nothing.
                if (timer_on) begin
                    none_active = 1'b1;
                    for (n = 0; n < NUM_LEDS; n++) begin
                        if (led_phase[n] != mlbs_pkg::PH_IDLE) begin
                            none_active = 1'b0;
                            if (step_led(n) && n < mlbs_pkg::PIN_W)
                                r.err[n] = 1'b1;
                        end
                    end
                    if (none_active) begin
                        timer_on = 1'b0;
                        r.ev     = mlbs_pkg::EV_IDLE;
                    end
                end
            end
            mlbs_pkg::REQ_START: begin
                if (it.idx >= NUM_LEDS) begin
                    r.status = mlbs_pkg::ST_BAD_INDEX;
                end else begin
                    n              = it.idx;
                    led_on_len[n]  = it.on_len;
                    led_off_len[n] = it.off_len;
                    led_cycles[n]  = it.reps;
                    if (it.on_len != 0 && it.off_len == 0 && it.reps == 0) begin
                        led_lit[n]   = 1'b1;   // steady on
                        led_phase[n] = mlbs_pkg::PH_IDLE;
                    end else if (it.on_len == 0 && it.reps == 0) begin
                        led_lit[n]   = 1'b0;   // steady off
                        led_phase[n] = mlbs_pkg::PH_IDLE;
                    end else begin
                        led_lit[n]   = 1'b0;
                        led_phase[n] = mlbs_pkg::PH_START;
                        timer_on     = 1'b1;
                    end
                    r.ev = mlbs_pkg::EV_STARTED;
                end
            end
            mlbs_pkg::REQ_STOP: begin
                clear_leds();
            end
            default: ;   // unknown request: ignore
        endcase
        for (n = 0; n < NUM_LEDS && n < mlbs_pkg::PIN_W; n++)
            r.pins[n] = led_lit[n] ^ cfg_mask[n];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge only
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin : item_driver
        t_blink_item itm;
        logic        raise;
        raise = start;   // hold an item that has not transferred yet
        if (i_rst_n && (!start || item_taken)) begin
            item_taken = 1'b0;
            raise      = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (pend_q.size() != 0 &&
                         !(pend_q[0].drain && (pin_result_q.size() != 0 || busy))) begin
                itm            = pend_q.pop_front();
                i_req_type     <= itm.req;
                i_led_index    <= itm.idx;
                i_on_ticks     <= itm.on_len;
                i_off_ticks    <= itm.off_len;
                i_repeat_count <= itm.reps;
                raise          = 1'b1;
                // Idle in bursts after some transfers so gaps land on every
                // phase of the block's work.
                if (!no_idle && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 7);
            end
        end
        start <= raise;
    end

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge, check results, predict transfers
    // ------------------------------------------------------------------

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_cnt++;
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_pin_result want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("Test completed with failures");
            $finish;
        end else if (i_rst_n) begin
            // Check the result first: a new transfer may share this edge.
            if (o_valid) begin
                if (pin_result_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result: expected none, actual pins=%0h %s",
                             $time, o_pin_levels,
                             $sformatf("status=%0h event=%0h err=%0h",
                                       o_status, o_event_res, o_error_mask));
                end else begin
                    want = pin_result_q.pop_front();
                    check_field("pin_levels", want.pins, o_pin_levels);
                    check_field("status", want.status, o_status);
                    check_field("event_res", want.ev, o_event_res);
                    check_field("error_mask", want.err, o_error_mask);
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                cfg_mask = i_cfg_data;
            if (start && !busy) begin
                pin_result_q.push_back(blink_predict('{req: i_req_type, idx: i_led_index,
                    on_len: i_on_ticks, off_len: i_off_ticks, reps: i_repeat_count,
                    drain: 1'b0}));
                item_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_blink_item mk_item(logic [1:0] req, logic [2:0] idx,
                                            logic [15:0] on_len, logic [15:0] off_len,
                                            logic [15:0] reps);
        t_blink_item it;
        it.req     = req;
        it.idx     = idx;
        it.on_len  = on_len;
        it.off_len = off_len;
        it.reps    = reps;
        it.drain   = 1'b0;
        return it;
    endfunction

    // Ticks carry random junk on the unused fields; the block must ignore it.
    function automatic t_blink_item tick_item();
        return mk_item(mlbs_pkg::REQ_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
    endfunction

    // Wait until the queue is drained and every result is back, then let the
    // block settle. Report anything still pending as missing.
    task automatic wait_idle();
        int unsigned n;
        while (pend_q.size() != 0 || start)
            @(posedge i_clk);
        n = 0;
        while (pin_result_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (pin_result_q.size() != 0) begin
            fail_cnt += pin_result_q.size();
            $display("%0t: missing results: expected %0d more, actual none",
                     $time, pin_result_q.size());
            pin_result_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mask(logic [3:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed bursts: a few starts with short lengths so the LEDs
    // actually cycle, then a run of ticks. Mix in stops, full-range starts,
    // bad indexes and unknown requests as noise.
    task automatic push_random(int unsigned count);
        int unsigned pushed;
        int unsigned sel;
        t_blink_item it;
        pushed = 0;
        while (pushed < count) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                repeat ($urandom_range(1, 3)) begin
                    it = mk_item(mlbs_pkg::REQ_START, 3'($urandom_range(0, NUM_LEDS - 1)),
                                 16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                                 16'($urandom_range(0, 3)));
                    it.drain = ($urandom_range(0, 49) == 0);
                    pend_q.push_back(it);
                    pushed++;
                end
                repeat ($urandom_range(2, 14)) begin
                    it       = tick_item();
                    it.drain = ($urandom_range(0, 49) == 0);
                    pend_q.push_back(it);
                    pushed++;
                end
            end else if (sel < 80) begin
                pend_q.push_back(mk_item(mlbs_pkg::REQ_STOP, 3'($urandom), 16'($urandom),
                                         16'($urandom), 16'($urandom)));
                pushed++;
            end else if (sel < 88) begin
                pend_q.push_back(mk_item(mlbs_pkg::REQ_START, 3'($urandom), 16'($urandom),
                                         16'($urandom), 16'($urandom)));
                pushed++;
            end else if (sel < 94) begin
                pend_q.push_back(tick_item());
                pushed++;
            end else if (sel < 97) begin
                pend_q.push_back(mk_item(mlbs_pkg::REQ_START,
                                         3'($urandom_range(NUM_LEDS, 7)),
                                         16'($urandom), 16'($urandom), 16'($urandom)));
                pushed++;
            end else begin
                pend_q.push_back(mk_item(REQ_UNKNOWN, 3'($urandom), 16'($urandom),
                                         16'($urandom), 16'($urandom)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        t_blink_item it;
        clear_leds();
        cfg_mask = '0;

        // Hold reset, then release it at a falling edge.
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mask(4'h0);

        // Directed part: ignored ticks and requests, bad indexes, steady on and
        // off, blinking, runaway patterns, stop, and a drain to the idle report.
        pend_q.push_back(mk_item(mlbs_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000));
        pend_q.push_back(mk_item(REQ_UNKNOWN, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_START, 3'd4, 16'h0001, 16'h0001, 16'h0001));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_START, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_START, 3'd0, 16'hFFFF, 16'h0000, 16'h0000));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_START, 3'd1, 16'h0000, 16'hFFFF, 16'h0000));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_START, 3'd2, 16'h0001, 16'h0002, 16'h0002));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_START, 3'd3, 16'h0000, 16'h0000, 16'h0000));
        repeat (6)
            pend_q.push_back(mk_item(mlbs_pkg::REQ_TICK, 3'd0, 16'h0, 16'h0, 16'h0));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_START, 3'd3, 16'h0000, 16'h0000, 16'h0003));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_START, 3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_STOP, 3'd0, 16'h0, 16'h0, 16'h0));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_TICK, 3'd0, 16'h0, 16'h0, 16'h0));
        pend_q.push_back(mk_item(mlbs_pkg::REQ_START, 3'd2, 16'h0001, 16'h0000, 16'h0001));
        // Pause the sender here until every result so far has come back.
        it       = mk_item(mlbs_pkg::REQ_TICK, 3'd0, 16'h0, 16'h0, 16'h0);
        it.drain = 1'b1;
        pend_q.push_back(it);
        repeat (3)
            pend_q.push_back(mk_item(mlbs_pkg::REQ_TICK, 3'd0, 16'h0, 16'h0, 16'h0));
        wait_idle();

        // Random part over several mask settings, all ones included.
        write_mask(4'hF);
        push_random(150);
        wait_idle();

        write_mask(4'($urandom));
        push_random(150);
        wait_idle();

        write_mask(4'h5);
        push_random(150);
        wait_idle();

        // Last stretch back to back, no sender idling.
        no_idle = 1'b1;
        write_mask(4'hA);
        push_random(150);
        wait_idle();

        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hdl/mlbs_pkg.sv
hdl/mlbs_step_unit.sv
hdl/multi_led_blink_sequencer_unit.sv
sim/tb_multi_led_blink_sequencer_unit.sv
